>>> rtl/core/vnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnt_pkg: shared types and constants of the value noise turbulence core
// Field widths, register indexes, request codes and the queued item format.
// ----------------------------------------------------------------------------
package vnt_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 256;
	localparam int unsigned DEF_MAX_HEIGHT = 256;
	localparam int unsigned DEF_MAX_SIZE   = 1024;

	localparam int unsigned POS_W     = 16;
	localparam int unsigned SIZE_W    = 11;
	localparam int unsigned NOISE_W   = 16;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned DIM_W     = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned RES_SHIFT = 2 * FRAC_W + 1;
	localparam int unsigned ACC_W     = 50;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_HEIGHT = 2'd1;
	localparam logic [DIM_W-1:0]     DIM_RESET        = 9'd256;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_t;

	// classified item as it waits between front and back
	typedef struct packed {
		logic                is_query;
		logic                wr_ok;
		logic                size_zero;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [SIZE_W-1:0]   size;
		logic [NOISE_W-1:0]  noise;
	} item_t;

endpackage
`default_nettype wire

>>> rtl/core/vnt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnt_div: restoring divider, one quotient bit per cycle
// Divides a pixel coordinate with appended fraction zeros by the octave size.
// ----------------------------------------------------------------------------
module vnt_div #(
	parameter int unsigned QW = 42
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [vnt_pkg::POS_W-1:0]     num,
	input  wire logic [vnt_pkg::SIZE_W-1:0]    den,
	output logic                               done,
	output logic [QW-1:0]                      quo
);
	localparam int unsigned PW = vnt_pkg::POS_W;
	localparam int unsigned SW = vnt_pkg::SIZE_W;
	localparam int unsigned CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] num_q;
	logic [SW-1:0] den_q;
	logic [SW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [SW:0]   trial;
	logic          ge;
	logic [SW-1:0] rem_n;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, num_q[PW-1]};
		ge    = trial >= {1'b0, den_q};
		rem_n = ge ? SW'(trial - {1'b0, den_q}) : SW'(trial);
	end

	// control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift numerator out, quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[PW-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/vnt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnt_front: input side of the turbulence core
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module vnt_front #(
	parameter int unsigned MAX_WIDTH  = vnt_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = vnt_pkg::DEF_MAX_HEIGHT,
	parameter int unsigned MAX_SIZE   = vnt_pkg::DEF_MAX_SIZE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          req_type,
	input  wire logic [vnt_pkg::POS_W-1:0]     pos_x,
	input  wire logic [vnt_pkg::POS_W-1:0]     pos_y,
	input  wire logic [vnt_pkg::SIZE_W-1:0]    octave_size,
	input  wire logic [vnt_pkg::NOISE_W-1:0]   noise_value,
	output logic                               item_valid,
	output vnt_pkg::item_t                     item,
	input  wire logic                          item_take
);
	localparam int unsigned SW       = vnt_pkg::SIZE_W;
	localparam int unsigned SIZE_MAX = (1 << SW) - 1;
	localparam logic [SW-1:0] SIZE_CAP = SW'((MAX_SIZE > SIZE_MAX) ? SIZE_MAX : MAX_SIZE);
	localparam int unsigned QD = 2;
	localparam int unsigned PTW = $clog2(QD);
	localparam int unsigned CNW = $clog2(QD + 1);

	vnt_pkg::item_t  cls;
	vnt_pkg::item_t  q_mem [QD];
	logic [PTW-1:0]  wr_ptr_q;
	logic [PTW-1:0]  rd_ptr_q;
	logic [CNW-1:0]  cnt_q;
	logic            push_ok;

	// classify the incoming item
	always_comb begin
		cls.is_query  = vnt_pkg::req_t'(req_type) == vnt_pkg::REQ_QUERY;
		cls.wr_ok     = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
		cls.size_zero = octave_size == '0;
		cls.size      = (octave_size > SIZE_CAP) ? SIZE_CAP : octave_size;
		cls.pos_x     = pos_x;
		cls.pos_y     = pos_y;
		cls.noise     = noise_value;
	end

	assign full       = cnt_q == CNW'(QD);
	assign push_ok    = push && !full;
	assign item_valid = cnt_q != '0;
	assign item       = q_mem[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (item_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_ok && !item_take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push_ok && item_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vnt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnt_back: execution side of the turbulence core
// Holds the noise table, walks the octaves of a query and keeps the result.
// ----------------------------------------------------------------------------
module vnt_back #(
	parameter int unsigned MAX_WIDTH  = vnt_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = vnt_pkg::DEF_MAX_HEIGHT,
	parameter int unsigned MAX_SIZE   = vnt_pkg::DEF_MAX_SIZE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	input  wire vnt_pkg::item_t                item,
	output logic                               item_take,
	input  wire logic [vnt_pkg::DIM_W-1:0]     table_width,
	input  wire logic [vnt_pkg::DIM_W-1:0]     table_height,
	output logic                               res_valid,
	output logic [vnt_pkg::NOISE_W-1:0]        res_value,
	input  wire logic                          res_pop
);
	localparam int unsigned PW    = vnt_pkg::POS_W;
	localparam int unsigned FW    = vnt_pkg::FRAC_W;
	localparam int unsigned NW    = vnt_pkg::NOISE_W;
	localparam int unsigned ACW   = vnt_pkg::ACC_W;
	localparam int unsigned RS    = vnt_pkg::RES_SHIFT;
	localparam int unsigned KMAX  = $clog2(MAX_SIZE + 1) - 1;
	localparam int unsigned QW    = PW + FW + KMAX;
	localparam int unsigned KW    = $clog2(KMAX + 2);
	localparam int unsigned MCW   = $clog2(PW + 1);
	localparam int unsigned XW    = $clog2(MAX_WIDTH);
	localparam int unsigned YW    = $clog2(MAX_HEIGHT);
	localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned WTW   = 2 * (FW + 1);
	localparam int unsigned PRW   = WTW + NW;
	localparam int unsigned SMW   = 49;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_MOD  = 7'b0000100,
		ST_RD   = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_ACC  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t                      st_q;
	logic [NW-1:0]               mem [DEPTH];
	logic [NW-1:0]               rdata_q;
	logic [vnt_pkg::SIZE_W-1:0]  size_q;
	logic [QW-1:0]               qx_q, qy_q, qx_div, qy_div;
	logic                        dx_done, dy_done, div_start;
	logic [XW-1:0]               rx_q, rx_n, x2;
	logic [YW-1:0]               ry_q, ry_n, y2;
	logic [XW:0]                 tx;
	logic [YW:0]                 ty;
	logic [WW-1:0]               w_c;
	logic [HW-1:0]               h_c;
	logic [MCW-1:0]              mcnt_q;
	logic [KW-1:0]               k_q;
	logic [1:0]                  corner_q;
	logic [FW-1:0]               fx, fy;
	logic [FW:0]                 gx, gy, wx, wy;
	logic [WTW-1:0]              weight_q;
	logic [PRW-1:0]              prod_q;
	logic [SMW-1:0]              samp_q, samp_sum;
	logic [ACW-1:0]              acc_q;
	logic                        more_oct;
	logic                        mem_we;
	logic [AW-1:0]               wr_addr, rd_addr;
	logic [XW-1:0]               xs;
	logic [YW-1:0]               ys;
	logic                        res_valid_q;
	logic [NW-1:0]               res_value_q;
	logic                        out_free;
	logic [ACW-RS-1:0]           res_raw;

	// clamp table dimensions in use
	always_comb begin
		if (table_width == '0) begin
			w_c = WW'(1);
		end else if (32'(table_width) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(table_width);
		end
		if (table_height == '0) begin
			h_c = HW'(1);
		end else if (32'(table_height) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(table_height);
		end
	end

	// one step of the wrap residue: r = (2r + next bit) mod dim
	always_comb begin
		tx   = {rx_q, qx_q[QW-1]};
		ty   = {ry_q, qy_q[QW-1]};
		rx_n = (tx >= (XW+1)'(w_c)) ? XW'(tx - (XW+1)'(w_c)) : XW'(tx);
		ry_n = (ty >= (YW+1)'(h_c)) ? YW'(ty - (YW+1)'(h_c)) : YW'(ty);
		x2   = (rx_q == '0) ? XW'(w_c - 1'b1) : rx_q - 1'b1;
		y2   = (ry_q == '0) ? YW'(h_c - 1'b1) : ry_q - 1'b1;
	end

	// corner selection and weights
	always_comb begin
		fx       = qx_q[QW-1 -: FW];
		fy       = qy_q[QW-1 -: FW];
		gx       = (FW+1)'(1 << FW) - {1'b0, fx};
		gy       = (FW+1)'(1 << FW) - {1'b0, fy};
		wx       = corner_q[0] ? gx : {1'b0, fx};
		wy       = corner_q[1] ? gy : {1'b0, fy};
		xs       = corner_q[0] ? x2 : rx_q;
		ys       = corner_q[1] ? y2 : ry_q;
		rd_addr  = AW'(32'(ys) * MAX_WIDTH + 32'(xs));
		wr_addr  = AW'(32'(item.pos_y) * MAX_WIDTH + 32'(item.pos_x));
		samp_sum = samp_q + SMW'(prod_q);
		more_oct = (32'(k_q) < KMAX) && ((32'(size_q) >> (32'(k_q) + 1)) != 0);
	end

	assign item_take = (st_q == ST_IDLE) && item_valid;
	assign mem_we    = item_take && !item.is_query && item.wr_ok;
	assign div_start = item_take && item.is_query && !item.size_zero;
	assign out_free  = !res_valid_q || res_pop;
	assign res_raw   = acc_q[ACW-1:RS];

	vnt_div #(.QW(QW)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (item.pos_x),
		.den    (item.size),
		.done   (dx_done),
		.quo    (qx_div)
	);

	vnt_div #(.QW(QW)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (item.pos_y),
		.den    (item.size),
		.done   (dy_done),
		.quo    (qy_div)
	);

	// noise table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= item.noise;
		end
		if (st_q == ST_RD) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			mcnt_q   <= '0;
			k_q      <= '0;
			corner_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (item_take && item.is_query) begin
						st_q <= item.size_zero ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (dx_done && dy_done) begin
						st_q   <= ST_MOD;
						mcnt_q <= '0;
					end
				end
				ST_MOD: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == MCW'(PW - 1)) begin
						st_q     <= ST_RD;
						k_q      <= '0;
						corner_q <= '0;
					end
				end
				ST_RD: begin
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					if (corner_q != 2'd3) begin
						corner_q <= corner_q + 1'b1;
						st_q     <= ST_RD;
					end else if (more_oct) begin
						corner_q <= '0;
						k_q      <= k_q + 1'b1;
						st_q     <= ST_RD;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the octave walk
	always_ff @(posedge clk) begin
		if (item_take) begin
			size_q <= item.size;
			acc_q  <= '0;
			samp_q <= '0;
		end
		if (st_q == ST_DIV && dx_done && dy_done) begin
			qx_q <= qx_div;
			qy_q <= qy_div;
			rx_q <= '0;
			ry_q <= '0;
		end
		if (st_q == ST_MOD) begin
			rx_q <= rx_n;
			ry_q <= ry_n;
			qx_q <= {qx_q[QW-2:0], 1'b0};
			qy_q <= {qy_q[QW-2:0], 1'b0};
		end
		if (st_q == ST_RD) begin
			weight_q <= wx * wy;
		end
		if (st_q == ST_MUL) begin
			prod_q <= weight_q * rdata_q;
		end
		if (st_q == ST_ACC) begin
			if (corner_q != 2'd3) begin
				samp_q <= samp_sum;
			end else begin
				acc_q  <= acc_q + ACW'(samp_sum >> k_q);
				samp_q <= '0;
				if (more_oct) begin
					rx_q <= rx_n;
					ry_q <= ry_n;
					qx_q <= {qx_q[QW-2:0], 1'b0};
					qy_q <= {qy_q[QW-2:0], 1'b0};
				end
			end
		end
	end

	// result register: saturate and hold until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (st_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DONE && out_free) begin
			res_value_q <= (res_raw > (ACW-RS)'({NW{1'b1}})) ? {NW{1'b1}} : NW'(res_raw);
		end
	end

	assign res_valid = res_valid_q;
	assign res_value = res_value_q;

`ifndef SYNTHESIS
	a_rx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |-> (32'(rx_q) < 32'(w_c)))
		else $error("column residue out of table");
	a_ry_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |-> (32'(ry_q) < 32'(h_c)))
		else $error("row residue out of table");
	a_rd_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |=> (st_q == ST_MUL))
		else $error("table read not followed by multiply");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ACC) |-> (32'(k_q) <= KMAX))
		else $error("octave index beyond limit");
`endif

endmodule
`default_nettype wire

>>> rtl/core/value_noise_turbulence_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// value_noise_turbulence_core: value noise turbulence with bilinear smoothing
// Stores a noise table and sums smoothed noise over octaves for a pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive fields and push while full is low. req_type write
//   stores noise_value at (pos_x, pos_y) and gives no result; query gives
//   one turbulence_value. A two-entry queue decouples input from execution.
//   Result queue: turbulence_value is valid while empty is low; pop takes it.
//   Config: cfg_valid/cfg_ready, cfg_index selects table_width or
//   table_height; write only while the core is idle. cfg_ready is always high.
//   Sequence: a write is stored when the execution unit takes it, if
//   pos_x < MAX_WIDTH and pos_y < MAX_HEIGHT. A query runs the serial
//   coordinate dividers (quotient width QW = 32 + log2(MAX_SIZE), 42 by
//   default), a 16-step wrap residue, then per octave four corner reads
//   of the table, each read / multiply / accumulate.
//   Reset: queues empty, dimensions 256; table contents are undefined.
//   A stalled result stops execution once the next query is finished;
//   input is taken until the front queue fills.
// ----------------------------------------------------------------------------
module value_noise_turbulence_core #(
	parameter int unsigned MAX_WIDTH  = vnt_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = vnt_pkg::DEF_MAX_HEIGHT,
	parameter int unsigned MAX_SIZE   = vnt_pkg::DEF_MAX_SIZE
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic                            req_type,
	input  wire logic [vnt_pkg::POS_W-1:0]       pos_x,
	input  wire logic [vnt_pkg::POS_W-1:0]       pos_y,
	input  wire logic [vnt_pkg::SIZE_W-1:0]      octave_size,
	input  wire logic [vnt_pkg::NOISE_W-1:0]     noise_value,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [vnt_pkg::NOISE_W-1:0]          turbulence_value,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [vnt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [vnt_pkg::DIM_W-1:0]       cfg_data
);
	vnt_pkg::item_t             item;
	logic                       item_valid;
	logic                       item_take;
	logic                       res_valid;
	logic [vnt_pkg::DIM_W-1:0]  width_q;
	logic [vnt_pkg::DIM_W-1:0]  height_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= vnt_pkg::DIM_RESET;
			height_q <= vnt_pkg::DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == vnt_pkg::REG_TABLE_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == vnt_pkg::REG_TABLE_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign empty     = !res_valid;

	vnt_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_SIZE   (MAX_SIZE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.octave_size (octave_size),
		.noise_value (noise_value),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take)
	);

	vnt_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_SIZE   (MAX_SIZE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take),
		.table_width  (width_q),
		.table_height (height_q),
		.res_valid    (res_valid),
		.res_value    (turbulence_value),
		.res_pop      (pop)
	);

endmodule
`default_nettype wire

>>> bench/value_noise_turbulence_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_turbulence_core_test: self-checking bench of the turbulence core
// Fills the table entries that each phase can read, then mixes entry writes
// and turbulence queries under several table sizes, predicting every result
// and checking it in order.
// ----------------------------------------------------------------------------
module value_noise_turbulence_core_test;

	localparam int unsigned PW  = vnt_pkg::POS_W;
	localparam int unsigned SZW = vnt_pkg::SIZE_W;
	localparam int unsigned NW  = vnt_pkg::NOISE_W;
	localparam int unsigned DW  = vnt_pkg::DIM_W;
	localparam int unsigned CIW = vnt_pkg::CFG_IDX_W;

	localparam int unsigned TBL_COLS   = vnt_pkg::DEF_MAX_WIDTH;
	localparam int unsigned TBL_ROWS   = vnt_pkg::DEF_MAX_HEIGHT;
	localparam int unsigned SIZE_LIMIT = vnt_pkg::DEF_MAX_SIZE;
	localparam logic [CIW-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CIW-1:0] REG_SPARE_B = 2'd3;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS  = 64;

	// turbulence predictor and store of expected values
	class turb_scoreboard;
		logic [NW-1:0]  noise_mem [TBL_COLS*TBL_ROWS];
		logic [DW-1:0]  dim_w;
		logic [DW-1:0]  dim_h;
		logic [NW-1:0]  turb_q [$];
		int unsigned    errors;

		function new();
			dim_w = vnt_pkg::DIM_RESET;
			dim_h = vnt_pkg::DIM_RESET;
			errors = 0;
		endfunction

		function void set_dim(logic [CIW-1:0] idx, logic [DW-1:0] val);
			if (idx == vnt_pkg::REG_TABLE_WIDTH)
				dim_w = val;
			else if (idx == vnt_pkg::REG_TABLE_HEIGHT)
				dim_h = val;
		endfunction

		function longint unsigned clamp_dim(logic [DW-1:0] v, int unsigned maxv);
			if (v == 0)
				return 1;
			return (v > maxv) ? maxv : v;
		endfunction

		// sum bilinear samples over halving octaves, scale and saturate
		function logic [NW-1:0] turbulence(longint unsigned px, longint unsigned py,
				longint unsigned size);
			longint unsigned w, h, qx, qy, fx, fy, gx, gy, x1, y1, x2, y2, smp, acc;
			int k;
			if (size == 0)
				return '0;
			if (size > SIZE_LIMIT)
				size = SIZE_LIMIT;
			w = clamp_dim(dim_w, TBL_COLS);
			h = clamp_dim(dim_h, TBL_ROWS);
			acc = 0;
			for (k = 0; (64'd1 << k) <= size; k++) begin
				qx = (px << (16 + k)) / size;
				qy = (py << (16 + k)) / size;
				fx = qx & 16'hFFFF;
				fy = qy & 16'hFFFF;
				gx = 65536 - fx;
				gy = 65536 - fy;
				x1 = (qx >> 16) % w;
				y1 = (qy >> 16) % h;
				x2 = (x1 + w - 1) % w;
				y2 = (y1 + h - 1) % h;
				smp = fx * fy * noise_mem[y1*TBL_COLS + x1]
					+ gx * fy * noise_mem[y1*TBL_COLS + x2]
					+ fx * gy * noise_mem[y2*TBL_COLS + x1]
					+ gx * gy * noise_mem[y2*TBL_COLS + x2];
				acc += smp >> k;
			end
			acc = acc >> vnt_pkg::RES_SHIFT;
			return (acc > 16'hFFFF) ? 16'hFFFF : acc[NW-1:0];
		endfunction

		// note an accepted input item
		function void note_item(vnt_pkg::req_t req, logic [PW-1:0] px, logic [PW-1:0] py,
				logic [SZW-1:0] size, logic [NW-1:0] nv);
			if (req == vnt_pkg::REQ_WRITE) begin
				if (px < TBL_COLS && py < TBL_ROWS)
					noise_mem[py*TBL_COLS + px] = nv;
			end else begin
				turb_q.push_back(turbulence(px, py, size));
			end
		endfunction

		// compare a popped result with the oldest expected value
		function void check_result(logic [NW-1:0] got);
			logic [NW-1:0] want;
			if (turb_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result turbulence_value=%h", got);
				return;
			end
			want = turb_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("turbulence_value mismatch: expected %h, got %h", want, got);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	logic             req_type = 1'b0;
	logic [PW-1:0]    pos_x = '0;
	logic [PW-1:0]    pos_y = '0;
	logic [SZW-1:0]   octave_size = '0;
	logic [NW-1:0]    noise_value = '0;
	logic             empty;
	logic             pop = 1'b0;
	logic [NW-1:0]    turbulence_value;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CIW-1:0]   cfg_index = '0;
	logic [DW-1:0]    cfg_data = '0;
	bit               quiet = 1'b0;
	// query coordinates stay within these so only filled entries are read
	logic [PW-1:0]    qx_lim = '1;
	logic [PW-1:0]    qy_lim = '1;
	turb_scoreboard   sb = new();

	value_noise_turbulence_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req_type(req_type),
		.pos_x(pos_x), .pos_y(pos_y), .octave_size(octave_size),
		.noise_value(noise_value), .empty(empty), .pop(pop),
		.turbulence_value(turbulence_value), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watch all three handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_item(vnt_pkg::req_t'(req_type), pos_x, pos_y, octave_size,
					noise_value);
			if (pop && !empty)
				sb.check_result(turbulence_value);
			if (cfg_valid && cfg_ready)
				sb.set_dim(cfg_index, cfg_data);
		end
	end

	// hold one item on the input until taken; idle before it at random
	task automatic send_item(vnt_pkg::req_t req, logic [PW-1:0] px, logic [PW-1:0] py,
			logic [SZW-1:0] size, logic [NW-1:0] nv, bit may_idle);
		if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= req;
		pos_x <= px;
		pos_y <= py;
		octave_size <= size;
		noise_value <= nv;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// write columns 0..cols-1 and last_col on rows 0..rows-1 and last_row
	task automatic fill_grid(int unsigned cols, int unsigned last_col, int unsigned rows,
			int unsigned last_row);
		int unsigned x, y;
		for (y = 0; y <= rows; y++)
			for (x = 0; x <= cols; x++)
				send_item(vnt_pkg::REQ_WRITE, PW'((x == cols) ? last_col : x),
					PW'((y == rows) ? last_row : y), '0, NW'($urandom), 1'b0);
	endtask

	// wait out every pending result and any write still in flight
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.turb_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIW-1:0] idx, logic [DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random writes (some out of range) and queries: mostly small sizes, a few full range and the largest
	task automatic random_items(int unsigned count);
		int unsigned pick;
		logic [PW-1:0] px, py;
		logic [SZW-1:0] size;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				if (pick == 0) begin
					px = PW'($urandom);
					py = PW'($urandom);
				end else begin
					px = PW'($urandom_range(0, TBL_COLS - 1));
					py = PW'($urandom_range(0, TBL_ROWS - 1));
				end
				send_item(vnt_pkg::REQ_WRITE, px, py, SZW'($urandom), NW'($urandom), 1'b1);
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					size = SZW'($urandom_range(0, 64));
				else if (pick < 9)
					size = SZW'($urandom_range(0, 2047));
				else
					size = SZW'(SIZE_LIMIT);
				px = PW'($urandom_range(0, 32'(qx_lim)));
				py = PW'($urandom_range(0, 32'(qy_lim)));
				send_item(vnt_pkg::REQ_QUERY, px, py, size, NW'($urandom), 1'b1);
			end
		end
	endtask

	// release results, with random stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			pop <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full table, small pixels: corner block plus the wrapped last row and column
		qx_lim = 16'd7;
		qy_lim = 16'd7;
		fill_grid(8, TBL_COLS - 1, 8, TBL_ROWS - 1);

		// directed: extremes, zero and oversize sizes, ignored writes
		send_item(vnt_pkg::REQ_WRITE, 16'd0, 16'd0, '0, 16'hFFFF, 1'b1);
		send_item(vnt_pkg::REQ_WRITE, PW'(TBL_COLS - 1), PW'(TBL_ROWS - 1), 11'h7FF,
			16'h0000, 1'b1);
		send_item(vnt_pkg::REQ_WRITE, PW'(TBL_COLS), 16'd0, '0, 16'h1234, 1'b1);
		send_item(vnt_pkg::REQ_WRITE, 16'd0, 16'hFFFF, '0, 16'h4321, 1'b1);
		send_item(vnt_pkg::REQ_WRITE, 16'hFFFF, 16'hFFFF, 11'h7FF, 16'hFFFF, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd0, 16'd0, 11'd0, '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'hFFFF, 16'hFFFF, 11'd0, 16'hFFFF, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd0, 16'd0, 11'd1, '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd7, 16'd7, SZW'(SIZE_LIMIT), '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd7, 16'd0, 11'h7FF, '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd5, 16'd3, SZW'(SIZE_LIMIT + 1), '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd7, 16'd7, 11'd2, '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd6, 16'd6, 11'd3, '0, 1'b1);
		random_items(PHASE_ITEMS);

		// single-entry table, any pixel
		drain();
		write_reg(vnt_pkg::REG_TABLE_WIDTH, 9'd1);
		write_reg(vnt_pkg::REG_TABLE_HEIGHT, 9'd1);
		qx_lim = '1;
		qy_lim = '1;
		send_item(vnt_pkg::REQ_QUERY, 16'hFFFF, 16'hFFFF, 11'd1, '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'hFFFF, 16'd0, SZW'(SIZE_LIMIT), '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd0, 16'hFFFF, 11'h7FF, '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'h8001, 16'h7FFF, SZW'(SIZE_LIMIT + 1), '0, 1'b1);
		send_item(vnt_pkg::REQ_QUERY, 16'd12345, 16'd54321, 11'd100, '0, 1'b1);
		random_items(PHASE_ITEMS);

		// oversize width and zero height, unknown indexes ignored
		drain();
		write_reg(vnt_pkg::REG_TABLE_WIDTH, 9'h1FF);
		write_reg(vnt_pkg::REG_TABLE_HEIGHT, 9'd0);
		write_reg(REG_SPARE_A, 9'h003);
		write_reg(REG_SPARE_B, 9'h1FF);
		qx_lim = 16'd7;
		qy_lim = '1;
		random_items(PHASE_ITEMS);

		// odd sizes
		drain();
		write_reg(vnt_pkg::REG_TABLE_WIDTH, 9'd7);
		write_reg(vnt_pkg::REG_TABLE_HEIGHT, 9'd3);
		qx_lim = '1;
		qy_lim = '1;
		fill_grid(6, 6, 2, 2);
		random_items(PHASE_ITEMS);

		// full width, one row short, no idling at the end
		drain();
		write_reg(vnt_pkg::REG_TABLE_WIDTH, 9'd256);
		write_reg(vnt_pkg::REG_TABLE_HEIGHT, 9'd255);
		qx_lim = 16'd7;
		qy_lim = 16'd7;
		fill_grid(8, TBL_COLS - 1, 8, TBL_ROWS - 2);
		random_items(PHASE_ITEMS / 2);
		quiet = 1'b1;
		random_items(PHASE_ITEMS / 2);
		drain();

		if (sb.errors == 0 && sb.turb_q.size() == 0)
			$display("[value_noise_turbulence_core] OK");
		else
			$display("[value_noise_turbulence_core] ERROR");
		$finish;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("[value_noise_turbulence_core] ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/vnt_pkg.sv
rtl/core/vnt_div.sv
rtl/core/vnt_front.sv
rtl/core/vnt_back.sv
rtl/core/value_noise_turbulence_core.sv
bench/value_noise_turbulence_core_test.sv
